// ----- rtl/core/ssd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the seven-segment scan driver: item types, sizes, segment table.
// Used by ssd_front, ssd_back and seven_segment_scan_driver.
package ssd_pkg;

   localparam int DIGITS      = 8;
   localparam int VALUE_W     = 32;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int POS_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CNT_W       = $clog2(VALUE_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SEG_BLANK = 8'hFF;
   localparam logic [7:0] SEL_FIRST = 8'h80;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef struct packed {
      logic               action;
      logic [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
   } rsp_item_type;

   typedef struct packed {
      logic               is_tick;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic valid;
   } cmd_hs_type;

   // active-low, common-anode pattern
   function automatic logic [7:0] seg_encode(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // double dabble correction: add 3 to every BCD digit of 5 or more
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/ssd_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts request items, classifies them and holds them in a short queue.
// Depends on ssd_pkg.
module ssd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssd_pkg::req_item_type req_item,
   output ssd_pkg::cmd_hs_type   cmd_hs_out,
   input  logic                  cmd_pop,
   output ssd_pkg::cmd_type      cmd_out
);

   ssd_pkg::cmd_type               queue_ff [ssd_pkg::QUEUE_DEPTH];
   logic [ssd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           push;
   logic                           pop;
   ssd_pkg::cmd_type               cmd_new;

   assign req_stall = (count_ff == ssd_pkg::QCNT_W'(ssd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && (count_ff != '0);

   assign cmd_new.is_tick = (req_item.action == ssd_pkg::ACTION_TICK);
   assign cmd_new.value   = req_item.value;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_out          = queue_ff[rd_ptr_ff];
   assign cmd_hs_out.valid = (count_ff != '0);

endmodule

// ----- rtl/core/ssd_back.sv -----
`timescale 1ns / 1ps
// Back end: double dabble converter, display buffer, scan position and result register.
// Depends on ssd_pkg.
module ssd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ssd_pkg::cmd_hs_type   cmd_hs,
   input  ssd_pkg::cmd_type      cmd_in,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssd_pkg::rsp_item_type rsp_item
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [ssd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ssd_pkg::VALUE_W-1:0]     bin_ff, bin_in;
   logic [ssd_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [ssd_pkg::BCD_W-1:0]       bcd_adj;
   logic [ssd_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [7:0]                      buf_ff [ssd_pkg::DIGITS];
   logic [7:0]                      buf_new [ssd_pkg::DIGITS];
   logic                            rsp_valid_ff, rsp_valid_in;
   ssd_pkg::rsp_item_type           rsp_item_ff, rsp_item_in;
   logic                            out_free;
   logic                            tick_go;
   logic                            load_go;
   logic                            lead_zero;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign tick_go  = (state_ff == ST_IDLE) && cmd_hs.valid && cmd_in.is_tick && out_free;
   assign load_go  = (state_ff == ST_IDLE) && cmd_hs.valid && !cmd_in.is_tick;
   assign cmd_pop  = tick_go || load_go;
   assign bcd_adj  = ssd_pkg::bcd_adjust(bcd_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_go) begin
               bin_in   = cmd_in.value;
               bcd_in   = '0;
               cnt_in   = ssd_pkg::CNT_W'(ssd_pkg::VALUE_W);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[ssd_pkg::BCD_W-2:0], bin_ff[ssd_pkg::VALUE_W-1]};
            bin_in = {bin_ff[ssd_pkg::VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == ssd_pkg::CNT_W'(1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // blank leading zeros, units digit always shown
   always_comb begin
      lead_zero = 1'b1;
      for (int i = ssd_pkg::DIGITS - 1; i >= 0; i--) begin
         lead_zero = lead_zero && (bcd_ff[4*i +: 4] == 4'd0);
         buf_new[i] = (lead_zero && (i != 0)) ? ssd_pkg::SEG_BLANK :
                      ssd_pkg::seg_encode(bcd_ff[4*i +: 4]);
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (tick_go) begin
         rsp_valid_in = 1'b1;
         rsp_item_in.digit_select = (32'(pos_ff) < 8) ?
                                    (ssd_pkg::SEL_FIRST >> pos_ff) : 8'h00;
         rsp_item_in.segments     = buf_ff[pos_ff];
         pos_in = (pos_ff == ssd_pkg::POS_W'(ssd_pkg::DIGITS - 1)) ?
                  '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
            buf_ff[i] <= ssd_pkg::SEG_BLANK;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_WRITE) begin
            for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
               buf_ff[i] <= buf_new[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- rtl/core/seven_segment_scan_driver.sv -----
`timescale 1ns / 1ps
// Eight-digit multiplexed seven-segment display driver, top level.
// Depends on ssd_pkg, ssd_front and ssd_back.
//
// A load item (action 0) converts value to decimal, keeps the low eight digits,
// blanks leading zeros and stores active-low segment bytes; it gives no result
// and occupies the back end while it is taken, through 32 double dabble
// shifts and for one buffer write. A tick item (action 1) gives one result, the
// one-hot digit select and segment byte of the current scan position, in the
// output register in the cycle after the back end takes it, and advances
// the position. A two-entry queue sits in front, so items are taken while a
// load is converting; rsp_stall only holds up ticks. The buffer resets blank.
module seven_segment_scan_driver (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssd_pkg::rsp_item_type rsp_item
);

   ssd_pkg::cmd_hs_type cmd_hs;
   ssd_pkg::cmd_type    cmd;
   logic                cmd_pop;

   ssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .cmd_hs_out (cmd_hs),
      .cmd_pop    (cmd_pop),
      .cmd_out    (cmd)
   );

   ssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_hs    (cmd_hs),
      .cmd_in    (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
